@@ sv/ltsc_pkg.sv @@
// shared constants, command type and character codes of the lyric tag converter
`default_nettype none

package ltsc_pkg;

  localparam int MAX_TAG = 32;
  localparam int IDX_W   = $clog2(MAX_TAG);
  localparam int CNT_W   = $clog2(MAX_TAG + 1);
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_EMIT,
    OP_FLUSH,
    OP_TIME
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic             flag;
    logic             last;
    logic [31:0]      ms;
  } cmd_t;

endpackage

`default_nettype wire

@@ sv/ltsc_front.sv @@
// front end: takes text bytes, tracks tag state and issues commands to the queue
`default_nettype none

module ltsc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          end_of_stream,
  output logic               push,
  output ltsc_pkg::cmd_t     push_cmd,
  input  wire logic          full
);
  import ltsc_pkg::*;

  localparam int HDR_NUM = 7;
  localparam int SLOTS   = 4;
  localparam int SL_OVF  = 0;
  localparam int SL_MAIN = 1;
  localparam int SL_CLS  = 2;
  localparam int SL_EOS  = 3;

  localparam logic [7:0] HDR_TEXT [HDR_NUM][7] = '{
    '{"[", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"[", "b", "y", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"[", "h", "a", "s", "h", 8'h00, 8'h00},
    '{"[", "a", "l", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"[", "s", "i", "g", "n", 8'h00, 8'h00},
    '{"[", "t", "o", "t", "a", "l", 8'h00},
    '{"[", "o", "f", "f", "s", "e", "t"}
  };
  localparam logic [2:0] HDR_LEN [HDR_NUM] = '{3'd3, 3'd3, 3'd5, 3'd3, 3'd5, 3'd6, 3'd7};

  logic               in_angle;
  logic               in_bracket;
  logic               skip;
  logic [CNT_W-1:0]   count;
  logic               seen_colon;
  logic               seen_comma;
  logic [31:0]        ms;
  logic               digits_done;
  logic [HDR_NUM-1:0] hdr_ok;

  logic               in_angle_next;
  logic               in_bracket_next;
  logic               skip_next;
  logic [CNT_W-1:0]   count_next;
  logic               seen_colon_next;
  logic               seen_comma_next;
  logic [31:0]        ms_next;
  logic               digits_done_next;
  logic [HDR_NUM-1:0] hdr_ok_next;

  cmd_t               slot [SLOTS];
  logic [SLOTS-1:0]   slot_v;
  cmd_t               cand [SLOTS];
  logic [SLOTS-1:0]   cand_v;
  logic [1:0]         sel;

  logic               accept;
  logic               ovf;
  logic               plain;
  logic               header;
  logic               main_emits;
  logic [CNT_W-1:0]   count_inc;
  logic [7:0]         folded;

  assign in_ready  = (slot_v == '0);
  assign accept    = in_valid && in_ready;
  assign ovf       = in_bracket && (count == CNT_W'(MAX_TAG));
  assign plain     = !in_bracket || ovf;
  assign count_inc = count + CNT_W'(1);
  assign folded    = (in_byte >= "A" && in_byte <= "Z") ? (in_byte | 8'h20) : in_byte;

  always_comb begin
    in_angle_next    = in_angle;
    in_bracket_next  = in_bracket;
    skip_next        = skip;
    count_next       = count;
    seen_colon_next  = seen_colon;
    seen_comma_next  = seen_comma;
    ms_next          = ms;
    digits_done_next = digits_done;
    hdr_ok_next      = hdr_ok;
    header           = 1'b0;
    cand_v           = '0;
    for (int i = 0; i < SLOTS; i++) begin
      cand[i] = '0;
    end

    // overflow: flush the full store, then treat the byte as text
    if (ovf) begin
      cand_v[SL_OVF]    = 1'b1;
      cand[SL_OVF].op   = OP_FLUSH;
      cand[SL_OVF].cnt  = count;
      cand[SL_OVF].flag = 1'b1;
      in_bracket_next   = 1'b0;
    end

    if (in_bracket && !ovf) begin
      cand_v[SL_MAIN]    = 1'b1;
      cand[SL_MAIN].op   = OP_STORE;
      cand[SL_MAIN].data = in_byte;
      cand[SL_MAIN].idx  = count[IDX_W-1:0];
      count_next         = count_inc;
      if (in_byte == CH_COLON) begin
        seen_colon_next = 1'b1;
      end
      if (in_byte == CH_COMMA) begin
        seen_comma_next = 1'b1;
      end
      if (!digits_done) begin
        if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
          ms_next = (ms << 3) + (ms << 1) + {24'b0, in_byte - CH_ZERO};
        end else begin
          digits_done_next = 1'b1;
        end
      end
      for (int p = 0; p < HDR_NUM; p++) begin
        if (count < CNT_W'(HDR_LEN[p]) && folded != HDR_TEXT[p][count[2:0]]) begin
          hdr_ok_next[p] = 1'b0;
        end
      end
      for (int p = 0; p < HDR_NUM; p++) begin
        if (hdr_ok_next[p] && count_inc >= CNT_W'(HDR_LEN[p])) begin
          header = 1'b1;
        end
      end
      if (in_byte == CH_RBRACK) begin
        in_bracket_next = 1'b0;
        if (seen_colon_next) begin
          if (header) begin
            skip_next = 1'b1;
          end else begin
            cand_v[SL_CLS]   = 1'b1;
            cand[SL_CLS].op  = OP_FLUSH;
            cand[SL_CLS].cnt = count_inc;
          end
        end else if (seen_comma_next) begin
          cand_v[SL_CLS]  = 1'b1;
          cand[SL_CLS].op = OP_TIME;
          cand[SL_CLS].ms = ms_next;
        end else begin
          cand_v[SL_CLS]   = 1'b1;
          cand[SL_CLS].op  = OP_FLUSH;
          cand[SL_CLS].idx = IDX_W'(1);
          cand[SL_CLS].cnt = count_inc;
        end
      end
    end

    if (plain) begin
      if (skip) begin
        if (in_byte == CH_NL) begin
          cand_v[SL_MAIN]    = 1'b1;
          cand[SL_MAIN].op   = OP_EMIT;
          cand[SL_MAIN].data = in_byte;
          skip_next          = 1'b0;
        end
      end else if (in_angle) begin
        if (in_byte == CH_GT) begin
          in_angle_next = 1'b0;
        end
      end else if (in_byte == CH_LT) begin
        in_angle_next = 1'b1;
      end else if (in_byte == CH_LBRACK) begin
        cand_v[SL_MAIN]    = 1'b1;
        cand[SL_MAIN].op   = OP_STORE;
        cand[SL_MAIN].data = in_byte;
        cand[SL_MAIN].idx  = '0;
        in_bracket_next    = 1'b1;
        count_next         = CNT_W'(1);
        seen_colon_next    = 1'b0;
        seen_comma_next    = 1'b0;
        ms_next            = '0;
        digits_done_next   = 1'b0;
        hdr_ok_next        = '1;
      end else begin
        cand_v[SL_MAIN]    = 1'b1;
        cand[SL_MAIN].op   = OP_EMIT;
        cand[SL_MAIN].data = in_byte;
      end
    end

    if (end_of_stream) begin
      if (in_bracket_next) begin
        cand_v[SL_EOS]    = 1'b1;
        cand[SL_EOS].op   = OP_FLUSH;
        cand[SL_EOS].cnt  = count_next;
        cand[SL_EOS].flag = 1'b1;
      end
      in_angle_next    = 1'b0;
      in_bracket_next  = 1'b0;
      skip_next        = 1'b0;
      count_next       = '0;
      seen_colon_next  = 1'b0;
      seen_comma_next  = 1'b0;
      ms_next          = '0;
      digits_done_next = 1'b0;
      hdr_ok_next      = '0;
    end

    // run_last goes on the final command that produces output
    main_emits         = cand_v[SL_MAIN] && (cand[SL_MAIN].op == OP_EMIT);
    cand[SL_EOS].last  = cand_v[SL_EOS];
    cand[SL_CLS].last  = !cand_v[SL_EOS];
    cand[SL_MAIN].last = main_emits && !cand_v[SL_CLS] && !cand_v[SL_EOS];
    cand[SL_OVF].last  = !main_emits && !cand_v[SL_CLS] && !cand_v[SL_EOS];
  end

  always_comb begin
    sel = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_v[i]) begin
        sel = 2'(i);
      end
    end
  end

  assign push     = (slot_v != '0) && !full;
  assign push_cmd = slot[sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_angle    <= 1'b0;
      in_bracket  <= 1'b0;
      skip        <= 1'b0;
      count       <= '0;
      seen_colon  <= 1'b0;
      seen_comma  <= 1'b0;
      ms          <= '0;
      digits_done <= 1'b0;
      hdr_ok      <= '0;
      slot_v      <= '0;
    end else if (accept) begin
      in_angle    <= in_angle_next;
      in_bracket  <= in_bracket_next;
      skip        <= skip_next;
      count       <= count_next;
      seen_colon  <= seen_colon_next;
      seen_comma  <= seen_comma_next;
      ms          <= ms_next;
      digits_done <= digits_done_next;
      hdr_ok      <= hdr_ok_next;
      slot_v      <= cand_v;
      for (int i = 0; i < SLOTS; i++) begin
        slot[i] <= cand[i];
      end
    end else if (push) begin
      slot_v[sel] <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ sv/ltsc_fifo.sv @@
// command queue between the front end and the back end
`default_nettype none

module ltsc_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ltsc_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output ltsc_pkg::cmd_t      pop_cmd,
  output logic                empty
);
  import ltsc_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W:0]   wp;
  logic [QPTR_W:0]   rp;

  assign empty   = (wp == rp);
  assign full    = (wp[QPTR_W] != rp[QPTR_W]) && (wp[QPTR_W-1:0] == rp[QPTR_W-1:0]);
  assign pop_cmd = entries[rp[QPTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (push) begin
        wp <= wp + (QPTR_W+1)'(1);
      end
      if (pop) begin
        rp <= rp + (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp[QPTR_W-1:0]] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ sv/ltsc_back.sv @@
// back end: bracket store, store replay, time conversion and output register
`default_nettype none

module ltsc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           empty,
  output logic                pop,
  input  wire ltsc_pkg::cmd_t pop_cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                run_last,
  output logic                overflow_flag
);
  import ltsc_pkg::*;

  localparam logic [3:0] TIME_LAST = 4'd9;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FL_RD,
    S_FL_EM,
    S_TM_CALC,
    S_TM_EM
  } state_t;

  state_t           state;

  logic [7:0]       store_mem [MAX_TAG];
  logic [7:0]       rd_data;
  logic             store_we;

  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] ptr_next;
  logic [CNT_W-1:0] end_cnt;
  logic             c_flag;
  logic             c_last;

  logic [31:0]      ms;
  logic [2:0]       tstep;
  logic [16:0]      minutes;
  logic [11:0]      hours;
  logic [15:0]      rem;
  logic [9:0]       crem;
  logic [54:0]      min_prod;
  logic [30:0]      hr_prod;
  logic [32:0]      min_ms;
  logic [31:0]      rem_full;
  logic [16:0]      hr_min;
  logic [16:0]      mm_full;
  logic [26:0]      sec_prod;
  logic [15:0]      sec_ms;
  logic [15:0]      crem_full;
  logic [17:0]      cc_prod;

  logic [6:0]       mm;
  logic [6:0]       ss;
  logic [6:0]       cc;
  logic [3:0]       eidx;
  logic [7:0]       time_char;
  logic             can_emit;
  logic             load;
  logic [7:0]       load_byte;
  logic             load_last;
  logic             load_flag;

  function automatic logic [3:0] tens(input logic [6:0] v);
    logic [14:0] prod;
    prod = {8'b0, v} * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] ones(input logic [6:0] v);
    logic [6:0] t10;
    logic [6:0] diff;
    t10  = {3'b0, tens(v)} * 7'd10;
    diff = v - t10;
    return diff[3:0];
  endfunction

  assign can_emit = !out_valid || out_ready;
  assign pop      = (state == S_IDLE) && !empty && (pop_cmd.op != OP_EMIT || can_emit);
  assign store_we = pop && (pop_cmd.op == OP_STORE);
  assign ptr_next = ptr + CNT_W'(1);

  // ms / 60000 as (ms >> 5) / 1875 by reciprocal multiply
  assign min_prod  = {28'b0, ms[31:5]} * 55'd146601551;
  // minutes / 60 as (minutes >> 2) / 15
  assign hr_prod   = {16'b0, minutes[16:2]} * 31'd34953;
  assign min_ms    = {16'b0, minutes} * 33'd60000;
  assign rem_full  = ms - min_ms[31:0];
  assign hr_min    = {5'b0, hours} * 17'd60;
  assign mm_full   = minutes - hr_min;
  // rem / 1000 as (rem >> 3) / 125
  assign sec_prod  = {14'b0, rem[15:3]} * 27'd8389;
  assign sec_ms    = {9'b0, ss} * 16'd1000;
  assign crem_full = rem - sec_ms;
  assign cc_prod   = {8'b0, crem} * 18'd205;

  always_comb begin
    case (eidx)
      4'd0:    time_char = CH_LBRACK;
      4'd1:    time_char = CH_ZERO | {4'b0, tens(mm)};
      4'd2:    time_char = CH_ZERO | {4'b0, ones(mm)};
      4'd3:    time_char = CH_COLON;
      4'd4:    time_char = CH_ZERO | {4'b0, tens(ss)};
      4'd5:    time_char = CH_ZERO | {4'b0, ones(ss)};
      4'd6:    time_char = CH_DOT;
      4'd7:    time_char = CH_ZERO | {4'b0, tens(cc)};
      4'd8:    time_char = CH_ZERO | {4'b0, ones(cc)};
      default: time_char = CH_RBRACK;
    endcase
  end

  always_comb begin
    load      = 1'b0;
    load_byte = pop_cmd.data;
    load_last = pop_cmd.last;
    load_flag = pop_cmd.flag;
    case (state)
      S_IDLE: begin
        load = pop && (pop_cmd.op == OP_EMIT);
      end
      S_FL_EM: begin
        load      = can_emit;
        load_byte = rd_data;
        load_last = c_last && (ptr_next == end_cnt);
        load_flag = c_flag;
      end
      S_TM_EM: begin
        load      = can_emit;
        load_byte = time_char;
        load_last = c_last && (eidx == TIME_LAST);
        load_flag = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[pop_cmd.idx] <= pop_cmd.data;
    end
    rd_data <= store_mem[ptr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid     <= 1'b1;
        out_byte      <= load_byte;
        run_last      <= load_last;
        overflow_flag <= load_flag;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (pop_cmd.op)
              OP_FLUSH: begin
                ptr     <= CNT_W'(pop_cmd.idx);
                end_cnt <= pop_cmd.cnt;
                c_flag  <= pop_cmd.flag;
                c_last  <= pop_cmd.last;
                state   <= S_FL_RD;
              end
              OP_TIME: begin
                ms     <= pop_cmd.ms;
                tstep  <= '0;
                c_last <= pop_cmd.last;
                state  <= S_TM_CALC;
              end
              default: begin
              end
            endcase
          end
        end
        S_FL_RD: begin
          state <= S_FL_EM;
        end
        S_FL_EM: begin
          if (can_emit) begin
            ptr   <= ptr_next;
            state <= (ptr_next == end_cnt) ? S_IDLE : S_FL_RD;
          end
        end
        S_TM_CALC: begin
          tstep <= tstep + 3'd1;
          case (tstep)
            3'd0: begin
              minutes <= min_prod[54:38];
            end
            3'd1: begin
              hours <= hr_prod[30:19];
              rem   <= rem_full[15:0];
            end
            3'd2: begin
              mm <= mm_full[6:0];
              ss <= sec_prod[26:20];
            end
            3'd3: begin
              crem <= crem_full[9:0];
            end
            default: begin
              cc    <= cc_prod[17:11];
              eidx  <= '0;
              state <= S_TM_EM;
            end
          endcase
        end
        S_TM_EM: begin
          if (can_emit) begin
            eidx <= eidx + 4'd1;
            if (eidx == TIME_LAST) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/lyric_tag_stream_converter_core.sv @@
// top level of the lyric tag stream converter: front end, command queue, back end
//
//   channel | signals                                   | dir | moves
//   --------+-------------------------------------------+-----+--------------------
//   in      | in_valid in_ready in_byte end_of_stream   | in  | one text byte
//   out     | out_valid out_ready out_byte run_last     | out | one converted byte
//           | overflow_flag                             |     |
//
// a request that queues nothing (angle tag or skipped line) is taken every cycle, else the
// input waits until all of its queued commands (up to 3 per request) have been pushed
// a bracket replay reads each byte through the registered store read port
// a timing bracket runs a reciprocal multiply conversion, then emits 10 output bytes
// reset clears control state only; store entries are written before they are read
// output backpressure holds the back end only, the input stalls once the queue is full
`default_nettype none

module lyric_tag_stream_converter_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_stream,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            overflow_flag
);
  import ltsc_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  ltsc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .push          (push),
    .push_cmd      (push_cmd),
    .full          (full)
  );

  ltsc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  ltsc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .pop           (pop),
    .pop_cmd       (pop_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .run_last      (run_last),
    .overflow_flag (overflow_flag)
  );

endmodule

`default_nettype wire
